// ===== hdl/frmh_pkg.sv =====
`timescale 1ns / 1ps
// frmh_pkg: shared types and constants of the frame reorder min-heap
// request structs, status codes, sequencer states, compare result
// no dependencies
package frmh_pkg;

  localparam int unsigned FIELD_BITS  = 16;
  localparam int unsigned HANDLE_BITS = 8;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LATE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [FIELD_BITS-1:0]  frame_number;
    logic [HANDLE_BITS-1:0] buffer_handle;
  } in_req_t;

  typedef struct packed {
    logic                   released;
    logic [FIELD_BITS-1:0]  out_frame_number;
    logic [HANDLE_BITS-1:0] out_handle;
    status_e                status;
  } out_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_UP,
    S_UP_CMP,
    S_TOP_RD,
    S_TOP_CMP,
    S_POP_RD,
    S_POP_LAST,
    S_DN,
    S_DN_KIDS,
    S_DN_HOLE
  } fsm_e;

endpackage

// ===== hdl/frmh_heap_ram.sv =====
`timescale 1ns / 1ps
// frmh_heap_ram: heap entry storage, one write port and two read ports
// read data registered; no dependencies
module frmh_heap_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 24,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/frmh_key_cmp.sv =====
`timescale 1ns / 1ps
// frmh_key_cmp: the one shared frame number comparator
// depends on frmh_pkg for the result struct
module frmh_key_cmp #(
  parameter int unsigned KEY_BITS = 16
) (
  input  logic [KEY_BITS-1:0] a_i,
  input  logic [KEY_BITS-1:0] b_i,
  output frmh_pkg::cmp_res_t  res_o
);

  assign res_o.lt = (a_i < b_i);
  assign res_o.eq = (a_i == b_i);

endmodule

// ===== hdl/frame_reorder_min_heap.sv =====
`timescale 1ns / 1ps
// frame_reorder_min_heap: top level, sequencer plus heap memory and shared comparator
// depends on frmh_pkg, frmh_heap_ram, frmh_key_cmp
//
// channel   dir  handshake                  payload
// in        in   in_valid_i / in_ready_o    in_req_i  (frame_number, buffer_handle)
// out       out  out_valid_o / out_ready_i  out_req_o (released, out_frame_number,
//                                                      out_handle, status)
// cfg       in   cfg_valid_i / cfg_ready_o  cfg_start_frame_i
//
// a late, in-order or full-heap request is accepted, then evaluated;
// a parked request sifts up level by level, then the heap top is read and compared;
// if the heap top then becomes due, a pop reads the last entry and moves the hole down
// level by level, and stops at a leaf or, when the last entry fits, short of one.
// the sift loops reuse one comparator and one memory.
// reset: expected frame is 1, heap empty; the heap memory itself is not cleared.
// stalls: a result waits in the output register; the sequencer only holds in the
// state that produces a result while that register is full and not taken.
module frame_reorder_min_heap #(
  parameter int unsigned HEAP_DEPTH = 16,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  frmh_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output frmh_pkg::out_req_t out_req_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [frmh_pkg::FIELD_BITS-1:0] cfg_start_frame_i
);

  localparam int unsigned IW = $clog2(HEAP_DEPTH);      // heap index
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);  // fill count
  localparam int unsigned LW = IW + 2;                  // child index, may pass depth
  localparam int unsigned HB = frmh_pkg::HANDLE_BITS;
  localparam int unsigned FB = frmh_pkg::FIELD_BITS;
  localparam int unsigned EW = FRAME_BITS + HB;         // entry is {key, handle}
  localparam logic [CW-1:0] FullCount = CW'(HEAP_DEPTH);

  // sequencer and state registers
  frmh_pkg::fsm_e          state_q, state_d;
  logic [FRAME_BITS-1:0]   exp_q, exp_d;
  logic [CW-1:0]           count_q, count_d;
  logic [IW-1:0]           i_q, i_d;
  logic [FRAME_BITS-1:0]   f_q, f_d;
  logic [HB-1:0]           t_q, t_d;
  logic [EW-1:0]           last_q, last_d;
  logic                    c_right_q, c_right_d;
  logic                    out_valid_q;
  frmh_pkg::out_req_t      out_q, out_d;
  logic                    out_load;
  logic                    out_free;

  // memory ports
  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [EW-1:0]           ram_wdata;
  logic [IW-1:0]           raddr_a, raddr_b;
  logic [EW-1:0]           rdata_a, rdata_b;

  // shared comparator
  logic [FRAME_BITS-1:0]   cmp_a, cmp_b;
  frmh_pkg::cmp_res_t      cmp_res;

  // key width conversions
  logic [FRAME_BITS-1:0]   in_key, cfg_key, res_key;
  logic [FB-1:0]           res_field;
  logic [HB-1:0]           res_tag;

  // index arithmetic around the hole
  logic [IW-1:0]           parent;
  logic [LW-1:0]           l_w, r_w, cnt_w;
  logic [EW-1:0]           child;
  logic [FRAME_BITS-1:0]   rd_a_key, rd_b_key, child_key, last_key;

  assign rd_a_key  = rdata_a[EW-1:HB];
  assign rd_b_key  = rdata_b[EW-1:HB];
  assign child     = c_right_q ? rdata_b : rdata_a;
  assign child_key = child[EW-1:HB];
  assign last_key  = last_q[EW-1:HB];

  assign parent = (i_q - IW'(1)) >> 1;
  assign l_w    = {1'b0, i_q, 1'b1};
  assign r_w    = l_w + LW'(1);
  assign cnt_w  = LW'(count_q);

  // frame numbers are held at FRAME_BITS internally, ports stay at field width
  if (FRAME_BITS > FB) begin : g_wide
    assign in_key    = {{(FRAME_BITS - FB){1'b0}}, in_req_i.frame_number};
    assign cfg_key   = {{(FRAME_BITS - FB){1'b0}}, cfg_start_frame_i};
    assign res_field = res_key[FB-1:0];
  end else if (FRAME_BITS == FB) begin : g_same
    assign in_key    = in_req_i.frame_number;
    assign cfg_key   = cfg_start_frame_i;
    assign res_field = res_key;
  end else begin : g_narrow
    assign in_key    = in_req_i.frame_number[FRAME_BITS-1:0];
    assign cfg_key   = cfg_start_frame_i[FRAME_BITS-1:0];
    assign res_field = {{(FB - FRAME_BITS){1'b0}}, res_key};
  end

  // what a result reports: the held request, or the heap top when popping
  always_comb begin
    if (state_q == frmh_pkg::S_TOP_CMP) begin
      res_key = rd_a_key;
      res_tag = rdata_a[HB-1:0];
    end else begin
      res_key = f_q;
      res_tag = t_q;
    end
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == frmh_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == frmh_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  frmh_heap_ram #(
    .DEPTH (HEAP_DEPTH),
    .WIDTH (EW),
    .AW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  frmh_key_cmp #(
    .KEY_BITS (FRAME_BITS)
  ) u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // sequencer: the item being moved is kept out of the heap and only the
  // hole travels, so each level costs one memory write
  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    count_d   = count_q;
    i_d       = i_q;
    f_d       = f_q;
    t_d       = t_q;
    last_d    = last_q;
    c_right_d = c_right_q;
    out_load  = 1'b0;
    out_d     = out_q;
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = {f_q, t_q};
    raddr_a   = '0;
    raddr_b   = '0;
    cmp_a     = f_q;
    cmp_b     = exp_q;

    unique case (state_q)
      frmh_pkg::S_IDLE: begin
        // stream restart
        if (cfg_valid_i) begin
          exp_d   = cfg_key;
          count_d = '0;
        end
        if (in_valid_i) begin
          f_d     = in_key;
          t_d     = in_req_i.buffer_handle;
          state_d = frmh_pkg::S_EVAL;
        end
      end

      frmh_pkg::S_EVAL: begin
        out_d.out_frame_number = res_field;
        out_d.out_handle       = res_tag;
        priority if (cmp_res.lt) begin
          // late frame, dropped
          out_d.released = 1'b0;
          out_d.status   = frmh_pkg::STAT_LATE;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = frmh_pkg::S_IDLE;
          end
        end else if (cmp_res.eq) begin
          // in order, straight through
          out_d.released = 1'b1;
          out_d.status   = frmh_pkg::STAT_OK;
          if (out_free) begin
            out_load = 1'b1;
            exp_d    = exp_q + FRAME_BITS'(1);
            state_d  = frmh_pkg::S_IDLE;
          end
        end else if (count_q == FullCount) begin
          out_d.released = 1'b0;
          out_d.status   = frmh_pkg::STAT_FULL;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = frmh_pkg::S_IDLE;
          end
        end else begin
          // park: hole opens at the end of the heap
          i_d     = count_q[IW-1:0];
          count_d = count_q + CW'(1);
          state_d = frmh_pkg::S_UP;
        end
      end

      frmh_pkg::S_UP: begin
        if (i_q == '0) begin
          ram_we  = 1'b1;
          state_d = frmh_pkg::S_TOP_RD;
        end else begin
          raddr_a = parent;
          state_d = frmh_pkg::S_UP_CMP;
        end
      end

      frmh_pkg::S_UP_CMP: begin
        raddr_a = parent;
        cmp_b   = rd_a_key;
        ram_we  = 1'b1;
        // stop at an equal parent
        if (cmp_res.lt) begin
          ram_wdata = rdata_a;
          i_d       = parent;
          state_d   = frmh_pkg::S_UP;
        end else begin
          state_d = frmh_pkg::S_TOP_RD;
        end
      end

      frmh_pkg::S_TOP_RD: begin
        state_d = frmh_pkg::S_TOP_CMP;
      end

      frmh_pkg::S_TOP_CMP: begin
        cmp_a                  = rd_a_key;
        out_d.released         = 1'b1;
        out_d.out_frame_number = res_field;
        out_d.out_handle       = res_tag;
        out_d.status           = frmh_pkg::STAT_OK;
        if (!cmp_res.eq) begin
          state_d = frmh_pkg::S_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          exp_d    = exp_q + FRAME_BITS'(1);
          count_d  = count_q - CW'(1);
          state_d  = frmh_pkg::S_POP_RD;
        end
      end

      frmh_pkg::S_POP_RD: begin
        raddr_a = count_q[IW-1:0];
        state_d = frmh_pkg::S_POP_LAST;
      end

      frmh_pkg::S_POP_LAST: begin
        last_d  = rdata_a;
        i_d     = '0;
        state_d = frmh_pkg::S_DN;
      end

      frmh_pkg::S_DN: begin
        raddr_a = l_w[IW-1:0];
        raddr_b = r_w[IW-1:0];
        if (l_w >= cnt_w) begin
          ram_we    = 1'b1;
          ram_wdata = last_q;
          state_d   = frmh_pkg::S_IDLE;
        end else begin
          state_d = frmh_pkg::S_DN_KIDS;
        end
      end

      frmh_pkg::S_DN_KIDS: begin
        raddr_a = l_w[IW-1:0];
        raddr_b = r_w[IW-1:0];
        cmp_a   = rd_b_key;
        cmp_b   = rd_a_key;
        // left child wins a tie
        c_right_d = (r_w < cnt_w) && cmp_res.lt;
        state_d   = frmh_pkg::S_DN_HOLE;
      end

      frmh_pkg::S_DN_HOLE: begin
        raddr_a = l_w[IW-1:0];
        raddr_b = r_w[IW-1:0];
        cmp_a   = child_key;
        cmp_b   = last_key;
        ram_we  = 1'b1;
        if (cmp_res.lt) begin
          ram_wdata = child;
          i_d       = c_right_q ? r_w[IW-1:0] : l_w[IW-1:0];
          state_d   = frmh_pkg::S_DN;
        end else begin
          ram_wdata = last_q;
          state_d   = frmh_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = frmh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frmh_pkg::S_IDLE;
      exp_q       <= FRAME_BITS'(1);
      count_q     <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      exp_q   <= exp_d;
      count_q <= count_d;
      i_q     <= i_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_q       <= f_d;
    t_q       <= t_d;
    last_q    <= last_d;
    c_right_q <= c_right_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // fill count never passes the heap size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("heap count beyond depth");

  // every released frame advances the expected counter by one
  a_release_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.released) |=> (exp_q == $past(exp_q) + FRAME_BITS'(1)))
    else $error("release without expected frame advance");

  // sift-down only compares against a child that lies inside the heap
  a_child_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frmh_pkg::S_DN_HOLE) |-> (l_w < cnt_w))
    else $error("sift-down child outside heap");

  // a result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("pending result overwritten");

endmodule

// ===== tb/sv/frame_reorder_min_heap_test.sv =====
`timescale 1ns / 1ps
// frame_reorder_min_heap_test: self-checking bench for the frame reorder min-heap
// depends on frmh_pkg and frame_reorder_min_heap; runs stand-alone, no files or arguments
module frame_reorder_min_heap_test;

  localparam int unsigned HEAP_SLOTS  = 16;
  localparam int unsigned RAND_ITEMS  = 950;
  // settle time, enough for a park plus a full-depth pop still in flight
  localparam int unsigned SETTLE      = 64;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 400000;

  // one line of the directed table: a restart with a new start frame, or a frame request
  typedef struct {
    bit                 is_cfg;
    logic [15:0]        num;
    logic [7:0]         tag;
    bit                 typed;
    frmh_pkg::out_req_t want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  frmh_pkg::in_req_t in_req = '0;
  logic       out_ready = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [15:0] cfg_start = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  frmh_pkg::out_req_t out_req_o;
  logic       cfg_ready_o;

  // mirror of the block: next frame due, heap of parked frames and their buffer tags
  logic [15:0] exp_frame;
  logic [15:0] hp_num [HEAP_SLOTS];
  logic [7:0]  hp_tag [HEAP_SLOTS];
  int unsigned hp_cnt;

  frmh_pkg::out_req_t outcome_q [$];
  stim_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  frame_reorder_min_heap dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .in_req_i          (in_req),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .out_req_o         (out_req_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_start_frame_i (cfg_start)
  );

  // predicts what one accepted frame request produces; returns 0 when the frame is only parked
  function automatic bit reorder_step(input frmh_pkg::in_req_t rq,
                                      output frmh_pkg::out_req_t res);
    logic [15:0] f;
    logic [7:0]  t;
    logic [15:0] tf;
    logic [7:0]  tt;
    int unsigned i, p, l, r, c;
    f = rq.frame_number;
    t = rq.buffer_handle;
    res.released         = 1'b0;
    res.out_frame_number = f;
    res.out_handle       = t;
    res.status           = frmh_pkg::STAT_OK;
    // late frame: echoed back and dropped, nothing else moves
    if (f < exp_frame) begin
      res.status = frmh_pkg::STAT_LATE;
      return 1'b1;
    end
    if (f != exp_frame) begin
      // no room left: echoed back and dropped
      if (hp_cnt >= HEAP_SLOTS) begin
        res.status = frmh_pkg::STAT_FULL;
        return 1'b1;
      end
      // sift-up, stopping at an equal parent
      i = hp_cnt;
      hp_num[i] = f;
      hp_tag[i] = t;
      hp_cnt++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (hp_num[i] < hp_num[p]) begin
          tf = hp_num[i]; tt = hp_tag[i];
          hp_num[i] = hp_num[p]; hp_tag[i] = hp_tag[p];
          hp_num[p] = tf; hp_tag[p] = tt;
          i = p;
        end else begin
          break;
        end
      end
      if (hp_num[0] != exp_frame) return 1'b0;
      f = hp_num[0];
      t = hp_tag[0];
      // pop: last entry to the root, then sift-down preferring the left child on ties
      hp_cnt--;
      hp_num[0] = hp_num[hp_cnt];
      hp_tag[0] = hp_tag[hp_cnt];
      i = 0;
      while (1) begin
        l = 2 * i + 1;
        r = l + 1;
        if (l >= hp_cnt) break;
        c = l;
        if (r < hp_cnt && hp_num[r] < hp_num[l]) c = r;
        if (hp_num[c] < hp_num[i]) begin
          tf = hp_num[c]; tt = hp_tag[c];
          hp_num[c] = hp_num[i]; hp_tag[c] = hp_tag[i];
          hp_num[i] = tf; hp_tag[i] = tt;
          i = c;
        end else begin
          break;
        end
      end
    end
    exp_frame            = exp_frame + 16'd1;
    res.released         = 1'b1;
    res.out_frame_number = f;
    res.out_handle       = t;
    res.status           = frmh_pkg::STAT_OK;
    return 1'b1;
  endfunction

  // directed table row; where typed, the result echoes the request with the given flag and status
  function automatic void add_row(input bit is_cfg, input logic [15:0] num,
                                  input logic [7:0] tag, input bit typed, input bit rel,
                                  input frmh_pkg::status_e st);
    stim_row_t row;
    row.is_cfg                = is_cfg;
    row.num                   = num;
    row.tag                   = tag;
    row.typed                 = typed;
    row.want.released         = rel;
    row.want.out_frame_number = num;
    row.want.out_handle       = tag;
    row.want.status           = st;
    plan.push_back(row);
  endfunction

  // offers one frame request and holds it until taken; valid stays high for a follow-up
  task automatic offer_frame(input frmh_pkg::in_req_t rq, input bit typed,
                             input frmh_pkg::out_req_t want,
                             output bit got, output frmh_pkg::out_req_t res);
    in_req   <= rq;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    got = reorder_step(rq, res);
    if (typed) begin
      got = 1'b1;
      res = want;
    end
    if (got) outcome_q.push_back(res);
  endtask

  // random gap after a request, lowering valid with a chance of gap_pct percent
  task automatic take_gap();
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // stream restart: drain every outcome, let any parked work settle, then load the start frame
  task automatic restart_stream(input logic [15:0] start);
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_start <= start;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    exp_frame = start;
    hp_cnt    = 0;
  endtask

  // receiver: random stalls, plus one long hold when asked so the block backs up
  initial begin : drive_ready
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // every taken result is matched against the oldest outcome still waiting
  always @(posedge clk_i) begin : check_results
    frmh_pkg::out_req_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, out_req_o);
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        if (out_req_o.released !== want.released) begin
          $display("%0t: released expected %0d actual %0d", $time, want.released,
                   out_req_o.released);
          mismatches++;
        end
        if (out_req_o.out_frame_number !== want.out_frame_number) begin
          $display("%0t: out_frame_number expected %0d actual %0d", $time,
                   want.out_frame_number, out_req_o.out_frame_number);
          mismatches++;
        end
        if (out_req_o.out_handle !== want.out_handle) begin
          $display("%0t: out_handle expected %h actual %h", $time, want.out_handle,
                   out_req_o.out_handle);
          mismatches++;
        end
        if (out_req_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_req_o.status);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    frmh_pkg::in_req_t  rq;
    frmh_pkg::out_req_t res;
    frmh_pkg::out_req_t none;
    logic [15:0] num;
    logic [15:0] base;
    logic [15:0] next_new;
    logic [15:0] window [$];
    bit          got;
    bit          ordered;
    int unsigned sent_cnt;
    int unsigned set_no;
    int unsigned set_len;
    int unsigned win_k;
    int unsigned pick;
    int unsigned idx;

    none      = '0;
    exp_frame = 16'd1;
    hp_cnt    = 0;

    // directed table, starting from the reset start frame of 1
    add_row(0, 16'd1,     8'hA5, 1, 1, frmh_pkg::STAT_OK);    // due frame goes straight out
    add_row(0, 16'd0,     8'hFF, 1, 0, frmh_pkg::STAT_LATE);  // below the due frame
    add_row(0, 16'd1,     8'h00, 1, 0, frmh_pkg::STAT_LATE);  // repeat of a released frame
    add_row(0, 16'hFFFF,  8'h5A, 0, 0, frmh_pkg::STAT_OK);    // largest frame parks
    add_row(0, 16'd3,     8'h11, 0, 0, frmh_pkg::STAT_OK);
    add_row(0, 16'd3,     8'h22, 0, 0, frmh_pkg::STAT_OK);    // equal key already parked
    add_row(0, 16'd2,     8'h33, 1, 1, frmh_pkg::STAT_OK);    // due frame, heap top waits
    add_row(0, 16'd6,     8'h44, 0, 0, frmh_pkg::STAT_OK);    // park lets the heap top out
    add_row(0, 16'd4,     8'h55, 1, 1, frmh_pkg::STAT_OK);    // leaves a stale 3 at the root
    // fill the remaining slots with descending frames; the stale root blocks any release
    for (int k = 0; k < 13; k++)
      add_row(0, 16'h0100 - 16'(k * 17), 8'(k * 19 + 7), 0, 0, frmh_pkg::STAT_OK);
    add_row(0, 16'd7,     8'hC3, 1, 0, frmh_pkg::STAT_FULL);  // no room left
    add_row(1, 16'd0,     8'h00, 0, 0, frmh_pkg::STAT_OK);    // restart at the lowest frame
    add_row(0, 16'd0,     8'h3C, 1, 1, frmh_pkg::STAT_OK);
    add_row(1, 16'hFFFF,  8'h00, 0, 0, frmh_pkg::STAT_OK);    // restart at the highest frame
    add_row(0, 16'hFFFF,  8'h96, 1, 1, frmh_pkg::STAT_OK);
    add_row(0, 16'd0,     8'h69, 1, 1, frmh_pkg::STAT_OK);    // due counter wrapped to zero

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    gap_pct   = 10;
    stall_pct = 10;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        restart_stream(row.num);
      end else begin
        rq.frame_number  = row.num;
        rq.buffer_handle = row.tag;
        offer_frame(rq, row.typed, row.want, got, res);
        take_gap();
      end
    end

    // random streams, each a restart followed by mostly near-order frames
    sent_cnt = 0;
    set_no   = 0;
    while (sent_cnt < RAND_ITEMS) begin
      set_len = $urandom_range(6, 40);
      win_k   = $urandom_range(1, 5);
      case ($urandom_range(0, 5))
        0:       base = 16'd0;
        1:       base = 16'hFFFF - 16'($urandom_range(0, 20));
        default: base = 16'($urandom);
      endcase
      if (sent_cnt >= RAND_ITEMS * 85 / 100) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       gap_pct = 0;
          1:       gap_pct = 5;
          2:       gap_pct = 20;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 15;
        endcase
      end
      restart_stream(base);
      // one stream whose in-order frames come strictly in sequence, with the receiver held off, so the block backs up
      if (set_no == 3) begin
        gap_pct = 0;
        win_k   = 1;
        set_len = 40;
        hold_asked++;
      end
      next_new = base;
      window.delete();
      for (int n = 0; n < set_len; n++) begin
        pick    = $urandom_range(0, 99);
        ordered = 1'b0;
        if (pick < 80) begin
          while (window.size() < win_k) begin
            window.push_back(next_new);
            next_new = next_new + 16'd1;
          end
          idx     = $urandom_range(0, window.size() - 1);
          num     = window[idx];
          window.delete(idx);
          ordered = 1'b1;
        end else if (pick < 88) begin
          num = exp_frame - 16'($urandom_range(1, 4));      // late or duplicate
        end else if (pick < 94) begin
          num = 16'($urandom);
        end else begin
          num = exp_frame + 16'($urandom_range(20, 300));   // far ahead
        end
        rq.frame_number  = num;
        rq.buffer_handle = 8'($urandom);
        offer_frame(rq, 1'b0, none, got, res);
        // a frame dropped on a full heap is offered again later
        if (ordered && got && res.status == frmh_pkg::STAT_FULL) window.push_back(num);
        take_gap();
        sent_cnt++;
      end
      set_no++;
    end

    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/frmh_pkg.sv
hdl/frmh_heap_ram.sv
hdl/frmh_key_cmp.sv
hdl/frame_reorder_min_heap.sv
tb/sv/frame_reorder_min_heap_test.sv
